[rtl/fixed_point_alu_assert.svh]
// Assertion macros for the fixed-point ALU
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

`ifndef SYNTHESIS

`define FPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fixed_point_alu: assertion failed");

`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fixed_point_alu: assertion failed");

`else

`define FPA_ASSERT(lbl, clk, rst_n, prop)
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fpa_pkg.sv]
// Shared types and constants for the fixed-point ALU
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_W        = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_t;

  typedef struct packed {
    logic              is_div;
    logic              dbz;
    logic              less;
    logic              equal;
    logic              greater;
    logic              neg;
    logic [WORD_W-1:0] res;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dvsr;
  } cell_t;

endpackage

[rtl/fpa_front.sv]
// Operand register, multiplier and per-operation result stages
`timescale 1ns / 1ps

module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int NUM_W     = 32 + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [3:0]          up_kind,
  input  logic signed [31:0]  up_a,
  input  logic signed [31:0]  up_b,
  output logic                dn_valid,
  input  logic                dn_ready,
  output fpa_pkg::cell_t      dn_data,
  output logic [NUM_W-1:0]    dn_dq
);
  import fpa_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  op_t                kind1_r;
  logic signed [31:0] a1_r, b1_r;

  logic signed [63:0] prod2_r;
  logic               is_mul2_r;
  logic [31:0]        amag2_r;
  logic [31:0]        res2_nxt;
  cell_t              c2_r, c2_nxt;

  cell_t              c3_r, c3_nxt;
  logic [NUM_W-1:0]   dq3_r;
  logic signed [63:0] mul_sh;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      kind1_r <= op_t'(up_kind);
      a1_r    <= up_a;
      b1_r    <= up_b;
    end
  end

  always_comb begin
    res2_nxt = '0;
    case (kind1_r)
      OP_ADD:      res2_nxt = a1_r + b1_r;
      OP_SUB:      res2_nxt = a1_r - b1_r;
      OP_INC:      res2_nxt = a1_r + 32'sd1;
      OP_DEC:      res2_nxt = a1_r - 32'sd1;
      OP_MIN:      res2_nxt = (a1_r <= b1_r) ? a1_r : b1_r;
      OP_MAX:      res2_nxt = (a1_r >= b1_r) ? a1_r : b1_r;
      OP_TO_INT:   res2_nxt = a1_r >>> FRAC_BITS;
      OP_FROM_INT: res2_nxt = a1_r << FRAC_BITS;
      default:     res2_nxt = '0;
    endcase

    c2_nxt         = '0;
    c2_nxt.is_div  = (kind1_r == OP_DIV);
    c2_nxt.dbz     = (kind1_r == OP_DIV) && (b1_r == 32'sd0);
    c2_nxt.less    = (a1_r < b1_r);
    c2_nxt.equal   = (a1_r == b1_r);
    c2_nxt.greater = (a1_r > b1_r);
    c2_nxt.neg     = a1_r[31] ^ b1_r[31];
    c2_nxt.res     = res2_nxt;
    c2_nxt.rem     = '0;
    c2_nxt.dvsr    = b1_r[31] ? 32'(-b1_r) : 32'(b1_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      prod2_r   <= 64'(a1_r) * 64'(b1_r);
      is_mul2_r <= (kind1_r == OP_MUL);
      amag2_r   <= a1_r[31] ? 32'(-a1_r) : 32'(a1_r);
      c2_r      <= c2_nxt;
    end
  end

  always_comb begin
    mul_sh     = prod2_r >>> FRAC_BITS;
    c3_nxt     = c2_r;
    c3_nxt.res = is_mul2_r ? mul_sh[31:0] : c2_r.res;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      c3_r  <= c3_nxt;
      dq3_r <= {amag2_r, {FRAC_BITS{1'b0}}};
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = c3_r;
  assign dn_dq    = dq3_r;

endmodule

[rtl/fpa_div_cell.sv]
// One restoring-division step cell of the quotient chain
`timescale 1ns / 1ps

module fpa_div_cell #(
  parameter int NUM_W = 32 + fpa_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  fpa_pkg::cell_t    up_data,
  input  logic [NUM_W-1:0]  up_dq,
  output logic              dn_valid,
  input  logic              dn_ready,
  output fpa_pkg::cell_t    dn_data,
  output logic [NUM_W-1:0]  dn_dq
);
  import fpa_pkg::*;

  logic             valid_r;
  cell_t            data_r, data_nxt;
  logic [NUM_W-1:0] dq_r, dq_nxt;
  logic [32:0]      trial;
  logic [33:0]      diff;
  logic             ge;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    trial    = {up_data.rem, up_dq[NUM_W-1]};
    diff     = {1'b0, trial} - {2'b00, up_data.dvsr};
    ge       = !diff[33];
    data_nxt = up_data;
    data_nxt.rem = ge ? diff[31:0] : trial[31:0];
    dq_nxt   = {up_dq[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
      dq_r   <= dq_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign dn_dq    = dq_r;

endmodule

[rtl/fixed_point_alu.sv]
// Top level of the pipelined signed fixed-point ALU
//
//   channel  direction  handshake          payload
//   in_      request in in_valid/in_stall  in_kind, in_operand_a, in_operand_b
//   out_     result out out_valid/out_stall out_result, out_less, out_equal,
//                                          out_greater, out_divide_by_zero
//
// One request per cycle enters while in_stall is low; each result passes the three
// front stages, the chain of 32 + FRAC_BITS division cells (one quotient bit per
// cell) and the output register. Every operation takes the chain.
// Reset (rst_n low, synchronous) empties all stages; data registers keep junk.
// Bubbles collapse under out_stall, so requests are taken until the chain fills.
`timescale 1ns / 1ps

module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_kind,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic               out_less,
  output logic               out_equal,
  output logic               out_greater,
  output logic               out_divide_by_zero
);
  import fpa_pkg::*;
  `include "fixed_point_alu_assert.svh"

  localparam int NUM_W = 32 + FRAC_BITS;

  logic             front_ready;
  logic             cell_v   [0:NUM_W];
  logic             cell_rdy [0:NUM_W];
  cell_t            cell_d   [0:NUM_W];
  logic [NUM_W-1:0] cell_dq  [0:NUM_W];

  logic             tail_ready;
  logic             out_valid_r;
  logic [31:0]      res_r, res_nxt;
  logic             less_r, equal_r, greater_r, dbz_r;
  logic [31:0]      quo;
  cell_t            tail;

  assign in_stall = !front_ready;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_kind  (in_kind),
    .up_a     (in_operand_a),
    .up_b     (in_operand_b),
    .dn_valid (cell_v[0]),
    .dn_ready (cell_rdy[0]),
    .dn_data  (cell_d[0]),
    .dn_dq    (cell_dq[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell #(
      .NUM_W (NUM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_v[i]),
      .up_ready (cell_rdy[i]),
      .up_data  (cell_d[i]),
      .up_dq    (cell_dq[i]),
      .dn_valid (cell_v[i+1]),
      .dn_ready (cell_rdy[i+1]),
      .dn_data  (cell_d[i+1]),
      .dn_dq    (cell_dq[i+1])
    );
  end

  assign tail_ready      = !out_valid_r || !out_stall;
  assign cell_rdy[NUM_W] = tail_ready;
  assign tail            = cell_d[NUM_W];

  always_comb begin
    quo = cell_dq[NUM_W][31:0];
    if (tail.is_div) begin
      if (tail.dbz) begin
        res_nxt = '0;
      end else begin
        res_nxt = tail.neg ? (32'd0 - quo) : quo;
      end
    end else begin
      res_nxt = tail.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail_ready) begin
      out_valid_r <= cell_v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_ready && cell_v[NUM_W]) begin
      res_r     <= res_nxt;
      less_r    <= tail.less;
      equal_r   <= tail.equal;
      greater_r <= tail.greater;
      dbz_r     <= tail.dbz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = res_r;
  assign out_less           = less_r;
  assign out_equal          = equal_r;
  assign out_greater        = greater_r;
  assign out_divide_by_zero = dbz_r;

  `FPA_ASSERT(a_dbz_zero, clk, rst_n, (out_valid_r && dbz_r) |-> (res_r == 32'd0))
  `FPA_ASSERT(a_flag_one, clk, rst_n, out_valid_r |-> $onehot({less_r, equal_r, greater_r}))
  `FPA_ASSERT_NEXT(a_tail_move, clk, rst_n, cell_v[NUM_W] && tail_ready, out_valid_r)

endmodule

[bench/tb.sv]
// Self-checking testbench for the pipelined signed fixed-point ALU
`timescale 1ns / 1ps

module tb;
  import fpa_pkg::*;

  localparam int          FRAC           = FRAC_BITS_DEF;
  localparam int          PERIOD         = 10;
  localparam int          RAND_ITEMS     = 625;
  localparam int          CALM_FROM      = 525;
  localparam int          LONG_HOLD_AT   = 150;
  localparam int          PAUSE_AT       = 350;
  localparam int          LONG_HOLD      = 150;
  localparam int          DRAIN_CYCLES   = 60;
  localparam longint      RUN_LIMIT_NS   = 2000000;
  localparam logic [3:0]  KIND_RSVD_LO   = 4'd10;
  localparam logic [3:0]  KIND_RSVD_HI   = 4'd15;
  localparam int          N_DIRECTED     = 25;

  typedef struct packed {
    logic [31:0] res;
    logic        less;
    logic        equal;
    logic        greater;
    logic        dbz;
  } alu_result_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    alu_result_t want;
  } alu_req_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_kind;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result;
  logic               out_less;
  logic               out_equal;
  logic               out_greater;
  logic               out_divide_by_zero;

  alu_result_t pending_results[$];
  int          errors    = 0;
  bit          calm      = 1'b0;
  bit          hold_long = 1'b0;

  alu_req_t directed_reqs [N_DIRECTED] = '{
    '{OP_ADD,      32'h00000000, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{OP_ADD,      32'h7FFFFFFF, 32'h00000001, 1'b1, '{32'h80000000, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{OP_SUB,      32'h80000000, 32'h00000001, 1'b1, '{32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_MUL,      32'h00000100, 32'h00000100, 1'b1, '{32'h00000100, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{OP_MUL,      32'h80000000, 32'h80000000, 1'b1, '{32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{OP_MUL,      32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, '0},
    '{OP_MUL,      32'hFFFFFFFF, 32'h00000001, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_DIV,      32'h00000100, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{OP_DIV,      32'h00000000, 32'h00000000, 1'b1, '{32'h00000000, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{OP_DIV,      32'h80000000, 32'hFFFFFFFF, 1'b0, '0},
    '{OP_DIV,      32'h00000300, 32'h00000200, 1'b1, '{32'h00000180, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{OP_DIV,      32'hFFFFFFFF, 32'h00000300, 1'b1, '{32'h00000000, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_INC,      32'h7FFFFFFF, 32'h00000000, 1'b1, '{32'h80000000, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{OP_DEC,      32'h80000000, 32'h00000000, 1'b1, '{32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_MIN,      32'h00000005, 32'h00000005, 1'b1, '{32'h00000005, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{OP_MIN,      32'h80000000, 32'h7FFFFFFF, 1'b1, '{32'h80000000, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_MAX,      32'h80000000, 32'h7FFFFFFF, 1'b1, '{32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_MAX,      32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, '{32'h7FFFFFFF, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{OP_TO_INT,   32'h80000000, 32'h00000000, 1'b1, '{32'hFF800000, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_TO_INT,   32'hFFFFFFFF, 32'h00000000, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{OP_FROM_INT, 32'h7FFFFFFF, 32'h00000000, 1'b1, '{32'hFFFFFF00, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{OP_FROM_INT, 32'h00000001, 32'h00000001, 1'b1, '{32'h00000100, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{KIND_RSVD_LO, 32'h00000001, 32'h00000002, 1'b1, '{32'h00000000, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{KIND_RSVD_HI, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{OP_MUL,      32'h7FFFFFFF, 32'h80000000, 1'b0, '0}
  };

  fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result         (out_result),
    .out_less           (out_less),
    .out_equal          (out_equal),
    .out_greater        (out_greater),
    .out_divide_by_zero (out_divide_by_zero)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic alu_result_t alu_compute(input logic [3:0] kind,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    longint      wide;
    r = '0;
    case (kind)
      OP_ADD:      r.res = a + b;
      OP_SUB:      r.res = a - b;
      OP_MUL: begin
        wide  = longint'(a) * longint'(b);
        wide  = wide >>> FRAC;
        r.res = wide[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dbz = 1'b1;
        end else begin
          wide  = longint'(a) <<< FRAC;
          wide  = wide / longint'(b);
          r.res = wide[31:0];
        end
      end
      OP_INC:      r.res = a + 32'sd1;
      OP_DEC:      r.res = a - 32'sd1;
      OP_MIN:      r.res = (a <= b) ? a : b;
      OP_MAX:      r.res = (a >= b) ? a : b;
      OP_TO_INT:   r.res = a >>> FRAC;
      OP_FROM_INT: r.res = a << FRAC;
      default:     r.res = '0;
    endcase
    r.less    = a < b;
    r.equal   = a == b;
    r.greater = a > b;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: w = 32'h7FFFFFFF;
          1: w = 32'h80000000;
          2: w = 32'hFFFFFFFF;
          default: w = 32'h00000001;
        endcase
      end
      2: w = $urandom_range(0, 2047) - 1024;
      3: w = ($urandom_range(0, 65535) - 32768) << 4;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic offer(input alu_req_t req);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= req.kind;
    in_operand_a <= req.a;
    in_operand_b <= req.b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(req.typed ? req.want : alu_compute(req.kind, req.a, req.b));
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    alu_req_t req;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= '0;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reqs[i]) offer(directed_reqs[i]);
    drain_pending();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= CALM_FROM);
      if (i == LONG_HOLD_AT) hold_long = 1'b1;
      if (i == PAUSE_AT) drain_pending();
      req       = '0;
      req.kind  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI))
                                              : 4'($urandom_range(OP_ADD, OP_FROM_INT));
      req.a     = pick_operand();
      req.b     = ($urandom_range(0, 7) == 0) ? req.a : pick_operand();
      offer(req);
    end

    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_stall
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result !== want.res) begin
          $error("result: expected %h, actual %h", want.res, out_result);
          errors++;
        end
        if (out_less !== want.less) begin
          $error("less: expected %b, actual %b", want.less, out_less);
          errors++;
        end
        if (out_equal !== want.equal) begin
          $error("equal: expected %b, actual %b", want.equal, out_equal);
          errors++;
        end
        if (out_greater !== want.greater) begin
          $error("greater: expected %b, actual %b", want.greater, out_greater);
          errors++;
        end
        if (out_divide_by_zero !== want.dbz) begin
          $error("divide_by_zero: expected %b, actual %b", want.dbz, out_divide_by_zero);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

[fixed_point_alu.f]
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div_cell.sv
rtl/fixed_point_alu.sv
bench/tb.sv
